FILE: src/mbglue_pkg.sv
// ----------------------------------------------------------------------------
// mbglue_pkg
// Shared types and constants for the motherboard I/O glue register block.
// ----------------------------------------------------------------------------
package mbglue_pkg;

   // Saturation limit of the memory-block counter.
   localparam logic [3:0] BLOCK_LIMIT = 4'd10;

   // Access kinds carried on the request tuser field.
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_FETCH = 2'd2
   } kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_UNSUPPORTED = 2'd1,
      STATUS_UNMAPPED    = 2'd2
   } status_type;

   // Port addresses outside the board range.
   localparam logic [15:0] PORT_MEMCTL       = 16'h0070;
   localparam logic [15:0] PORT_NMI_LATCH    = 16'h00a0;
   localparam logic [15:0] PORT_JUMPER       = 16'h0100;
   localparam logic [15:0] PORT_VIDEO_SELECT = 16'h0102;
   localparam logic [15:0] PORT_DIAGNOSTIC   = 16'h0378;
   localparam logic [15:0] PORT_VIDEO_SETUP  = 16'h46e8;
   localparam logic [13:0] PORT_EMS_BASE     = 14'h2100;   // 8400h..8403h, upper bits
   localparam logic [11:0] PORT_BOARD_BASE   = 12'h006;    // 60h..6Fh, upper bits

   // Low nibble of the board ports.
   localparam logic [3:0] BOARD_KBD_DATA = 4'h0;
   localparam logic [3:0] BOARD_SPEAKER  = 4'h1;
   localparam logic [3:0] BOARD_STATUS   = 4'h2;
   localparam logic [3:0] BOARD_FIXED    = 4'h3;
   localparam logic [3:0] BOARD_GLUE64   = 4'h4;
   localparam logic [3:0] BOARD_CONTROL  = 4'h5;
   localparam logic [3:0] BOARD_KEYLOCK  = 4'h6;
   localparam logic [3:0] BOARD_KEY67    = 4'h7;
   localparam logic [3:0] BOARD_KEY68    = 4'h8;
   localparam logic [3:0] BOARD_KEY69    = 4'h9;
   localparam logic [3:0] BOARD_KEY6A    = 4'ha;
   localparam logic [3:0] BOARD_BLOCK    = 4'hb;
   localparam logic [3:0] BOARD_GLUE6C   = 4'hc;
   localparam logic [3:0] BOARD_OPEN6D   = 4'hd;
   localparam logic [3:0] BOARD_OPEN6E   = 4'he;
   localparam logic [3:0] BOARD_GLUE6F   = 4'hf;

   // Glue register slots.
   localparam logic [1:0] GLUE_SLOT64 = 2'd0;
   localparam logic [1:0] GLUE_SLOT6B = 2'd1;
   localparam logic [1:0] GLUE_SLOT6C = 2'd2;
   localparam logic [1:0] GLUE_SLOT6F = 2'd3;

   // Read masks and fixed values.
   localparam logic [7:0] GLUE64_READ_MASK = 8'h8f;
   localparam logic [7:0] KEYLOCK_BIT      = 8'h04;
   localparam logic [7:0] BLOCK_FULL_VALUE = 8'hc0;
   localparam logic [7:0] FIXED_63_VALUE   = 8'h08;
   localparam logic [7:0] OPEN_PORT_VALUE  = 8'hff;
   localparam logic [7:0] CONTROL_RESET    = 8'h80;
   localparam logic [7:0] JUMPER_RESET     = 8'hff;

   // One bus access.
   typedef struct packed {
      logic [7:0]  write_byte;
      logic [3:0]  access_size;
      logic [15:0] port_address;
      logic [1:0]  kind;
   } req_item_type;

   // One answer.
   typedef struct packed {
      logic       keyboard_irq_clear;
      logic       gate_level;
      logic       gate_update;
      status_type status;
      logic [7:0] read_byte;
   } rsp_item_type;

   // Readable board state. Write-only latches have no read path and are not kept.
   typedef struct packed {
      logic [7:0]      speaker;
      logic [7:0]      control;
      logic [3:0]      block_count;
      logic [3:0][7:0] glue;
      logic [3:0][7:0] keylock;
      logic [7:0]      nmi_latch;
      logic [7:0]      diagnostic;
   } glue_state_type;

   // Board state after reset: control at its power-on value, key lock set.
   localparam glue_state_type STATE_RESET = '{
      speaker:     8'h00,
      control:     CONTROL_RESET,
      block_count: 4'd0,
      glue:        '0,
      keylock:     {8'h00, 8'h00, 8'h00, KEYLOCK_BIT},
      nmi_latch:   8'h00,
      diagnostic:  8'h00
   };

endpackage

FILE: src/mbglue_decode.sv
// ----------------------------------------------------------------------------
// mbglue_decode
// Port decoder: answer and next board state for one registered access.
// ----------------------------------------------------------------------------
module mbglue_decode (
   input  mbglue_pkg::req_item_type   req,
   input  logic [7:0]                 jumper,
   input  mbglue_pkg::glue_state_type state_cur,
   output mbglue_pkg::glue_state_type state_next,
   output mbglue_pkg::rsp_item_type   rsp
);
   import mbglue_pkg::*;

   logic size_one;
   logic is_read;
   logic is_write;
   logic basic_ok;
   logic board_port;
   logic ems_port;
   logic [3:0] nib;
   logic [7:0] rd;

   always_comb begin
      size_one   = (req.access_size == 4'd1);
      is_read    = (req.kind == KIND_READ);
      is_write   = (req.kind == KIND_WRITE);
      basic_ok   = size_one && (is_read || is_write);
      board_port = (req.port_address[15:4] == PORT_BOARD_BASE);
      ems_port   = (req.port_address[15:2] == PORT_EMS_BASE);
      nib        = req.port_address[3:0];
   end

   // Decode and update.
   always_comb begin
      state_next             = state_cur;
      rd                     = 8'h00;
      rsp.status             = STATUS_OK;
      rsp.gate_update        = 1'b0;
      rsp.gate_level         = 1'b0;
      rsp.keyboard_irq_clear = 1'b0;

      if (board_port) begin
         if (!basic_ok) begin
            rsp.status = STATUS_UNSUPPORTED;
         end else if (is_read) begin
            case (nib)
               BOARD_KBD_DATA: rsp.keyboard_irq_clear = 1'b1;
               BOARD_SPEAKER:  rd = state_cur.speaker;
               BOARD_STATUS: begin
                  if (state_cur.block_count >= BLOCK_LIMIT) rd = BLOCK_FULL_VALUE;
               end
               BOARD_FIXED:    rd = FIXED_63_VALUE;
               BOARD_GLUE64:   rd = state_cur.glue[GLUE_SLOT64] & GLUE64_READ_MASK;
               BOARD_CONTROL:  rd = state_cur.control;
               BOARD_KEYLOCK, BOARD_KEY67, BOARD_KEY68, BOARD_KEY69: begin
                  rd = state_cur.keylock[nib[1:0] - 2'd2];
               end
               BOARD_KEY6A:    rd = 8'h00;
               BOARD_BLOCK:    rd = state_cur.glue[GLUE_SLOT6B];
               BOARD_GLUE6C:   rd = state_cur.glue[GLUE_SLOT6C];
               BOARD_GLUE6F:   rd = state_cur.glue[GLUE_SLOT6F];
               default:        rd = OPEN_PORT_VALUE;
            endcase
         end else begin
            case (nib)
               BOARD_SPEAKER: begin
                  state_next.speaker = req.write_byte;
                  rsp.gate_update    = 1'b1;
                  rsp.gate_level     = req.write_byte[0];
               end
               BOARD_GLUE64:  state_next.glue[GLUE_SLOT64] = req.write_byte;
               BOARD_GLUE6C:  state_next.glue[GLUE_SLOT6C] = req.write_byte;
               BOARD_GLUE6F:  state_next.glue[GLUE_SLOT6F] = req.write_byte;
               BOARD_CONTROL: state_next.control = req.write_byte;
               // The key lock bit of port 66h is not writable.
               BOARD_KEYLOCK: begin
                  state_next.keylock[0] = (req.write_byte & ~KEYLOCK_BIT) |
                                          (state_cur.keylock[0] & KEYLOCK_BIT);
               end
               BOARD_KEY67, BOARD_KEY68, BOARD_KEY69: begin
                  state_next.keylock[nib[1:0] - 2'd2] = req.write_byte;
               end
               // Bit 0 of port 6Bh steps the block counter up to its limit.
               BOARD_BLOCK: begin
                  state_next.glue[GLUE_SLOT6B] = {req.write_byte[7:1], 1'b0};
                  if (req.write_byte[0] && (state_cur.block_count < BLOCK_LIMIT)) begin
                     state_next.block_count = state_cur.block_count + 4'd1;
                  end
               end
               default: begin
               end
            endcase
         end
      end else if ((req.port_address == PORT_NMI_LATCH) ||
                   (req.port_address == PORT_DIAGNOSTIC)) begin
         if (!basic_ok) begin
            rsp.status = STATUS_UNSUPPORTED;
         end else if (req.port_address == PORT_NMI_LATCH) begin
            if (is_read) rd = state_cur.nmi_latch;
            else state_next.nmi_latch = req.write_byte;
         end else begin
            if (is_read) rd = state_cur.diagnostic;
            else state_next.diagnostic = req.write_byte;
         end
      end else if (req.port_address == PORT_JUMPER) begin
         if (!size_one || !is_read) rsp.status = STATUS_UNSUPPORTED;
         else rd = jumper;
      end else if ((req.port_address == PORT_MEMCTL) ||
                   (req.port_address == PORT_VIDEO_SELECT) ||
                   (req.port_address == PORT_VIDEO_SETUP) || ems_port) begin
         // Write-only latches: a write is acknowledged, nothing reads them back.
         if (!size_one || !is_write) rsp.status = STATUS_UNSUPPORTED;
      end else begin
         rsp.status = STATUS_UNMAPPED;
      end

      rsp.read_byte = (rsp.status == STATUS_OK) ? rd : 8'h00;
   end

endmodule

FILE: src/motherboard_io_glue_registers.sv
// ----------------------------------------------------------------------------
// motherboard_io_glue_registers
// Emulated PC motherboard glue ports behind a request/response stream.
// ----------------------------------------------------------------------------
// The block takes one I/O access per clock cycle while the response side is
// not stalled and answers every access with exactly one response, in order.
// An access is captured in the request register when accepted, decoded
// against the board state and placed in the response register when the
// response register is empty or being taken; a stall holds it in the request
// register. The rate of one access per cycle is set by the single decode
// stage that reads and updates the board state. req_tready stays high whenever
// the request register is empty or the response register is empty or being
// taken in the same cycle. The user must write the jumper byte through the csr
// port only while no access is in flight; the block itself does not enforce it.
module motherboard_io_glue_registers (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // port_address[15:0], access_size[19:16],
                                    // write_byte[27:20], zero[31:28]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_byte[7:0], gate_update[8], gate_level[9],
                                    // keyboard_irq_clear[10], zero[15:11]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   // Configuration.
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import mbglue_pkg::*;

   logic           req_valid_ff;
   req_item_type   req_ff;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_ff;
   glue_state_type state_ff;
   glue_state_type state_in;
   rsp_item_type   rsp_in;
   logic [7:0]     jumper_ff;
   logic           stage_move;
   logic           req_fire;

   // Handshake: the decode stage moves when the response register can take it.
   assign stage_move = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || stage_move;
   assign req_fire   = req_tvalid && req_tready;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff.kind         <= req_tuser;
         req_ff.port_address <= req_tdata[15:0];
         req_ff.access_size  <= req_tdata[19:16];
         req_ff.write_byte   <= req_tdata[27:20];
      end
   end

   // Jumper configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         jumper_ff <= JUMPER_RESET;
      end else if (csr_wr_en) begin
         jumper_ff <= csr_wr_data;
      end
   end

   // Port decoder.
   mbglue_decode u_decode (
      .req        (req_ff),
      .jumper     (jumper_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   // Board state, updated when a decoded access leaves the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_valid_ff && stage_move) begin
         state_ff <= state_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_move) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff && stage_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.keyboard_irq_clear, rsp_ff.gate_level,
                        rsp_ff.gate_update, rsp_ff.read_byte};
   assign rsp_tuser  = rsp_ff.status;

   // Checks.
   a_block_count_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.block_count <= BLOCK_LIMIT)
      else $error("block counter passed its limit");

   a_state_only_on_move: assert property (@(posedge clock) disable iff (reset)
      !(req_valid_ff && stage_move) |=> $stable(state_ff))
      else $error("board state changed without a decoded access");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STATUS_OK)) |->
         ((rsp_ff.read_byte == 8'h00) && !rsp_ff.gate_update &&
          !rsp_ff.keyboard_irq_clear))
      else $error("failed access carries data or a pulse");

   a_gate_level_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.gate_level) |-> rsp_ff.gate_update)
      else $error("gate level without a gate update");

endmodule
